[rtl/core/hrb_pkg.sv]
// Shared types, phase codes and the hex digit decoder for the hex record converter.
`timescale 1ns / 1ps
`default_nettype none

package hrb_pkg;

  localparam logic [2:0] PH_WAIT   = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_OFS_HI = 3'd2;
  localparam logic [2:0] PH_OFS_LO = 3'd3;
  localparam logic [2:0] PH_KIND   = 3'd4;
  localparam logic [2:0] PH_DATA   = 3'd5;

  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] KIND_DATA  = 8'h00;
  localparam logic [7:0] KIND_BASE  = 8'h04;

  localparam logic ITEM_BYTE    = 1'b0;
  localparam logic ITEM_SUMMARY = 1'b1;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  data_byte;
    logic [31:0] start_address;
    logic [31:0] byte_total;
    logic        no_data_error;
    logic        final_item;
  } hrb_result_t;

  typedef struct packed {
    logic [1:0]  num;
    hrb_result_t first;
    hrb_result_t second;
  } hrb_push_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h61 + 8'h0a);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h41 + 8'h0a);
    end else begin
      v = 4'hf;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/hrb_parser.sv]
// Record parser: per-character state update and result generation.
`timescale 1ns / 1ps
`default_nettype none

module hrb_parser import hrb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] char_i,
  input  wire logic       eot_i,
  output hrb_push_t       push_o
);

  logic [2:0]  phase_q, phase_d;
  logic [3:0]  hi_q, hi_d;
  logic        second_q, second_d;
  logic [7:0]  fbc_q, fbc_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] ofs_q, ofs_d;
  logic [7:0]  kind_q, kind_d;
  logic [31:0] base_q, base_d;
  logic        base_seen_q, base_seen_d;
  logic [15:0] first_ofs_q, first_ofs_d;
  logic        data_seen_q, data_seen_d;
  logic [31:0] bytes_q, bytes_d;

  logic [3:0]  digit;
  logic [7:0]  b;
  logic        emit;
  hrb_result_t byte_res;
  hrb_result_t sum_res;

  assign digit = hex_digit(char_i);
  assign b     = {hi_q, digit};

  always_comb begin
    phase_d     = phase_q;
    hi_d        = hi_q;
    second_d    = second_q;
    fbc_d       = fbc_q;
    len_d       = len_q;
    ofs_d       = ofs_q;
    kind_d      = kind_q;
    base_d      = base_q;
    base_seen_d = base_seen_q;
    first_ofs_d = first_ofs_q;
    data_seen_d = data_seen_q;
    bytes_d     = bytes_q;
    emit        = 1'b0;

    if (phase_q == PH_WAIT) begin
      if (char_i == CHAR_COLON) begin
        phase_d  = PH_LEN;
        second_d = 1'b0;
        hi_d     = '0;
        fbc_d    = '0;
      end
    end else if (!second_q) begin
      hi_d     = digit;
      second_d = 1'b1;
    end else begin
      second_d = 1'b0;
      unique case (phase_q)
        PH_LEN: begin
          len_d   = b;
          phase_d = PH_OFS_HI;
        end
        PH_OFS_HI: begin
          ofs_d   = {b, 8'h00};
          phase_d = PH_OFS_LO;
        end
        PH_OFS_LO: begin
          ofs_d   = {ofs_q[15:8], b};
          phase_d = PH_KIND;
        end
        PH_KIND: begin
          kind_d = b;
          fbc_d  = '0;
          if (b == KIND_DATA && !data_seen_q) begin
            data_seen_d = 1'b1;
            first_ofs_d = ofs_q;
          end
          if (b == KIND_BASE && !base_seen_q) begin
            base_d = '0;
          end
          if (len_q == 8'h00) begin
            if (b == KIND_BASE && !base_seen_q) begin
              base_seen_d = 1'b1;
            end
            phase_d = PH_WAIT;
          end else begin
            phase_d = PH_DATA;
          end
        end
        default: begin
          if (kind_q == KIND_DATA) begin
            emit = 1'b1;
            if (bytes_q != '1) begin
              bytes_d = bytes_q + 32'd1;
            end
          end else if (kind_q == KIND_BASE && !base_seen_q) begin
            base_d = {base_q[23:0], b};
          end
          fbc_d = fbc_q + 8'd1;
          if (fbc_d >= len_q) begin
            if (kind_q == KIND_BASE && !base_seen_q) begin
              base_seen_d = 1'b1;
            end
            phase_d = PH_WAIT;
          end else begin
            phase_d = PH_DATA;
          end
        end
      endcase
    end
  end

  always_comb begin
    byte_res               = '0;
    byte_res.item_kind     = ITEM_BYTE;
    byte_res.data_byte     = b;
    byte_res.final_item    = !eot_i;

    sum_res                = '0;
    sum_res.item_kind      = ITEM_SUMMARY;
    sum_res.start_address  = data_seen_d ? ({base_d[15:0], 16'h0000} + {16'h0000, first_ofs_d})
                                         : 32'h0;
    sum_res.byte_total     = bytes_d;
    sum_res.no_data_error  = !data_seen_d;
    sum_res.final_item     = 1'b1;

    push_o.num    = accept_i ? ({1'b0, emit} + {1'b0, eot_i}) : 2'd0;
    push_o.first  = emit ? byte_res : sum_res;
    push_o.second = sum_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WAIT;
      hi_q        <= '0;
      second_q    <= 1'b0;
      fbc_q       <= '0;
      len_q       <= '0;
      ofs_q       <= '0;
      kind_q      <= '0;
      base_q      <= '0;
      base_seen_q <= 1'b0;
      first_ofs_q <= '0;
      data_seen_q <= 1'b0;
      bytes_q     <= '0;
    end else if (accept_i) begin
      if (eot_i) begin
        phase_q     <= PH_WAIT;
        hi_q        <= '0;
        second_q    <= 1'b0;
        fbc_q       <= '0;
        len_q       <= '0;
        ofs_q       <= '0;
        kind_q      <= '0;
        base_q      <= '0;
        base_seen_q <= 1'b0;
        first_ofs_q <= '0;
        data_seen_q <= 1'b0;
        bytes_q     <= '0;
      end else begin
        phase_q     <= phase_d;
        hi_q        <= hi_d;
        second_q    <= second_d;
        fbc_q       <= fbc_d;
        len_q       <= len_d;
        ofs_q       <= ofs_d;
        kind_q      <= kind_d;
        base_q      <= base_d;
        base_seen_q <= base_seen_d;
        first_ofs_q <= first_ofs_d;
        data_seen_q <= data_seen_d;
        bytes_q     <= bytes_d;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/hrb_out_fifo.sv]
// Result queue: takes up to two results per cycle, hands out one per cycle while the reader is ready.
`timescale 1ns / 1ps
`default_nettype none

module hrb_out_fifo import hrb_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire hrb_push_t push_i,
  output logic       room_o,
  output logic       valid_o,
  input  wire logic  ready_i,
  output hrb_result_t data_o
);

  hrb_result_t         mem_q [FifoDepth];
  logic [PtrW-1:0]     wr_q, wr_d;
  logic [PtrW-1:0]     rd_q, rd_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pop;
  logic [PtrW-1:0]     wr_next;

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= CntW'(FifoDepth - 2));
  assign data_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;
  assign wr_next = wr_q + PtrW'(1);

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.num);
    rd_d  = pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.num) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("result queue count beyond depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num != 2'd0) |-> room_o)
    else $error("result pushed without room");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.num == 2'd0) |=> cnt_q == $past(cnt_q) - CntW'(1))
    else $error("result queue count did not drop on pop");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty result queue with pointer gap");
`endif

endmodule

`default_nettype wire

[rtl/core/hex_record_to_binary.sv]
// Top level of the hex record to binary stream converter.
//
//  channel  dir  tdata (low bit up)                                    tuser      tlast
//  s_       in   [7:0] text_char                                       -          end_of_text
//  m_       out  [7:0] data_byte, [39:8] start_address,                item_kind  final_item
//                [71:40] byte_total, [72] no_data_error, [79:73] zero
//
//  One character is taken per cycle while ready is high; its results enter a four-entry
//  result queue in the same edge and leave one per cycle while m_tready is high, so a
//  character that ends a text with a data byte yields two results: byte, then summary.
//  Input ready drops while the queue holds more than two results.
//  Reset clears parser state and queue pointers; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module hex_record_to_binary import hrb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [7:0]  s_tdata_i,   // text_char
  input  wire logic        s_tlast_i,
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [79:0]      m_tdata_o,   // data_byte, start_address, byte_total, no_data_error
  output logic             m_tuser_o,   // item_kind
  output logic             m_tlast_o
);

  hrb_push_t   push;
  hrb_result_t res;
  logic        accept;

  assign accept = s_tvalid_i && s_tready_o;

  hrb_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .char_i   (s_tdata_i),
    .eot_i    (s_tlast_i),
    .push_o   (push)
  );

  hrb_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (s_tready_o),
    .valid_o (m_tvalid_o),
    .ready_i (m_tready_i),
    .data_o  (res)
  );

  assign m_tdata_o = {7'h00, res.no_data_error, res.byte_total, res.start_address,
                      res.data_byte};
  assign m_tuser_o = res.item_kind;
  assign m_tlast_o = res.final_item;

endmodule

`default_nettype wire

[tb/sv/hex_record_to_binary_test.sv]
// Self-checking testbench for the hex record to binary stream converter.
`timescale 1ns / 1ps

module hex_record_to_binary_test;
  import hrb_pkg::*;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i  = '0;
  logic        s_tlast_i  = 1'b0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [79:0] m_tdata_o;
  logic        m_tuser_o;
  logic        m_tlast_o;

  hex_record_to_binary dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  always #4 clk_i = ~clk_i;

  // Parser mirror
  logic [2:0]  scan_phase;
  logic [3:0]  nib_hi;
  logic        low_digit_due;
  logic [7:0]  rec_fill;
  logic [7:0]  rec_len;
  logic [15:0] rec_ofs;
  logic [7:0]  rec_kind;
  logic [31:0] base_word;
  logic        base_locked;
  logic [15:0] first_ofs;
  logic        data_found;
  logic [31:0] emitted_count;

  hrb_result_t expected_results[$];
  logic [7:0]  text_buf[$];

  bit idle_on     = 1'b1;
  bit digit_noise = 1'b0;
  int stall_cycles = 0;
  int chars_sent = 0;
  int texts_sent = 0;
  int bytes_checked = 0;
  int summaries_checked = 0;
  int mismatches = 0;

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return c[3:0];
    if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) return c[3:0] + 4'd9;
    return 4'hf;
  endfunction

  function void clear_parser();
    scan_phase    = PH_WAIT;
    nib_hi        = '0;
    low_digit_due = 1'b0;
    rec_fill      = '0;
    rec_len       = '0;
    rec_ofs       = '0;
    rec_kind      = '0;
    base_word     = '0;
    base_locked   = 1'b0;
    first_ofs     = '0;
    data_found    = 1'b0;
    emitted_count = '0;
  endfunction

  function void close_if_full();
    if (rec_fill >= rec_len) begin
      if (rec_kind == KIND_BASE) base_locked = 1'b1;
      scan_phase = PH_WAIT;
    end else begin
      scan_phase = PH_DATA;
    end
  endfunction

  task automatic predict_char(input logic [7:0] c, input logic eot);
    hrb_result_t res;
    logic [7:0]  b;
    logic        byte_out;
    res = '0;
    byte_out = 1'b0;
    if (scan_phase == PH_WAIT) begin
      if (c == CHAR_COLON) begin
        scan_phase    = PH_LEN;
        low_digit_due = 1'b0;
        nib_hi        = '0;
        rec_fill      = '0;
      end
    end else if (!low_digit_due) begin
      nib_hi        = digit_of(c);
      low_digit_due = 1'b1;
    end else begin
      b = {nib_hi, digit_of(c)};
      low_digit_due = 1'b0;
      case (scan_phase)
        PH_LEN: begin
          rec_len    = b;
          scan_phase = PH_OFS_HI;
        end
        PH_OFS_HI: begin
          rec_ofs    = {b, 8'h00};
          scan_phase = PH_OFS_LO;
        end
        PH_OFS_LO: begin
          rec_ofs[7:0] = b;
          scan_phase   = PH_KIND;
        end
        PH_KIND: begin
          rec_kind = b;
          rec_fill = '0;
          if (b == KIND_DATA && !data_found) begin
            data_found = 1'b1;
            first_ofs  = rec_ofs;
          end
          if (b == KIND_BASE && !base_locked) base_word = '0;
          close_if_full();
        end
        default: begin
          if (rec_kind == KIND_DATA) begin
            res.item_kind = ITEM_BYTE;
            res.data_byte = b;
            byte_out = 1'b1;
            if (emitted_count != '1) emitted_count++;
          end else if (rec_kind == KIND_BASE && !base_locked) begin
            base_word = {base_word[23:0], b};
          end
          rec_fill++;
          close_if_full();
        end
      endcase
    end
    if (byte_out) begin
      res.final_item = !eot;
      expected_results.push_back(res);
    end
    if (eot) begin
      res = '0;
      res.item_kind     = ITEM_SUMMARY;
      res.start_address = data_found ? (base_word << 16) + 32'(first_ofs) : 32'h0;
      res.byte_total    = emitted_count;
      res.no_data_error = !data_found;
      res.final_item    = 1'b1;
      expected_results.push_back(res);
      clear_parser();
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic eot);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= c;
    s_tlast_i  <= eot;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    predict_char(c, eot);
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      send_char(text_buf[i], i == text_buf.size() - 1);
    end
    text_buf.delete();
    texts_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic put_str(input string s);
    foreach (s[i]) text_buf.push_back(s[i]);
  endtask

  task automatic put_hex(input logic [7:0] b);
    logic [3:0] nib;
    for (int k = 1; k >= 0; k--) begin
      nib = b[4*k +: 4];
      if (digit_noise && $urandom_range(0, 49) == 0) begin
        text_buf.push_back(8'($urandom_range(0, 255)));
      end else if (nib < 4'd10) begin
        text_buf.push_back(8'h30 + 8'(nib));
      end else begin
        text_buf.push_back(($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10);
      end
    end
  endtask

  task automatic put_record(input logic [7:0] kind, input logic [7:0] len,
                            input logic [15:0] ofs);
    text_buf.push_back(CHAR_COLON);
    put_hex(len);
    put_hex(ofs[15:8]);
    put_hex(ofs[7:0]);
    put_hex(kind);
    repeat (len) put_hex(8'($urandom_range(0, 255)));
    put_hex(8'($urandom_range(0, 255)));
    case ($urandom_range(0, 3))
      0: put_str("\r\n");
      1: put_str("\n");
      2: put_str(" ");
      default: ;
    endcase
  endtask

  task automatic run_random_texts(input int char_budget);
    int         budget_end;
    int         pick;
    int         keep;
    logic [7:0] c;
    logic [7:0] kind;
    logic [7:0] len;
    budget_end  = chars_sent + char_budget;
    digit_noise = 1'b1;
    while (chars_sent < budget_end) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 30)) text_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 3)) begin
          c = 8'($urandom_range(0, 255));
          text_buf.push_back(c == CHAR_COLON ? 8'h23 : c);
        end
        repeat ($urandom_range(1, 4)) begin
          pick = $urandom_range(0, 9);
          kind = pick < 6 ? KIND_DATA : pick < 8 ? KIND_BASE : 8'($urandom_range(0, 255));
          len  = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(6, 24))
                                              : 8'($urandom_range(0, 5));
          put_record(kind, len, 16'($urandom_range(0, 65535)));
        end
        // cut the text short at a random character
        if ($urandom_range(0, 4) == 0) begin
          keep = $urandom_range(1, text_buf.size());
          while (text_buf.size() > keep) void'(text_buf.pop_back());
        end
      end
      send_text();
    end
    digit_noise = 1'b0;
  endtask

  task automatic test_empty_text();
    text_buf.push_back(8'h00);
    send_text();
  endtask

  // invalid digits and a colon inside the offset, end of text on a data byte
  task automatic test_data_record_extremes();
    put_str(":01");
    text_buf.push_back(8'hff);
    text_buf.push_back(8'h00);
    put_str(":F00fF");
    send_text();
  endtask

  task automatic test_base_records();
    put_str(":00000004:0112340000\n");
    send_text();
  endtask

  task automatic test_cut_off_records();
    put_str(":0200000412");
    send_text();
    put_str(":03000700");
    send_text();
  endtask

  task automatic test_full_length_record();
    put_record(KIND_BASE, 8'd6, 16'($urandom_range(0, 65535)));
    put_record(KIND_DATA, 8'h81, 16'($urandom_range(0, 65535)));
    put_str("\n");
    send_text();
  endtask

  task automatic test_random_texts();
    run_random_texts(60);
  endtask

  task automatic test_drain_pause();
    run_random_texts(10);
    wait_drained();
    run_random_texts(10);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    run_random_texts(30);
  endtask

  always @(posedge clk_i) begin
    if (stall_cycles > 0) begin
      stall_cycles--;
      m_tready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_cycles = $urandom_range(0, 13);
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    hrb_result_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (expected_results.size() == 0) begin
        $error("unrequested result: kind %0d tdata %h last %0d",
               m_tuser_o, m_tdata_o, m_tlast_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("item_kind", 32'(want.item_kind), 32'(m_tuser_o));
        check_field("data_byte", 32'(want.data_byte), 32'(m_tdata_o[7:0]));
        check_field("start_address", want.start_address, m_tdata_o[39:8]);
        check_field("byte_total", want.byte_total, m_tdata_o[71:40]);
        check_field("no_data_error", 32'(want.no_data_error), 32'(m_tdata_o[72]));
        check_field("final_item", 32'(want.final_item), 32'(m_tlast_o));
        if (want.item_kind == ITEM_SUMMARY) summaries_checked++;
        else bytes_checked++;
      end
    end
  end

  initial begin
    clear_parser();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_text();
    test_data_record_extremes();
    test_base_records();
    test_cut_off_records();
    test_full_length_record();
    test_random_texts();
    test_drain_pause();
    test_steady_stream();
    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Streamed %0d characters in %0d texts; checked %0d data bytes and %0d summaries.",
             chars_sent, texts_sent, bytes_checked, summaries_checked);
    $display("Texts mixed base and data records, invalid digits, cut-off records and noise.");
    if (mismatches == 0) begin
      $display("hex_record_to_binary test passed");
    end else begin
      $display("hex_record_to_binary test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("hex_record_to_binary test failed");
    $finish;
  end

endmodule
